>>> hdl/dtcm_pkg.sv
// ----------------------------------------------------------------------------
// dtcm_pkg
// Shared types, constants and helpers for the DTC fault confirmation monitor.
// ----------------------------------------------------------------------------
package dtcm_pkg;

	// Sizing
	localparam int NUM_CODES   = 8;
	localparam int COUNT_WIDTH = 8;
	localparam int IDX_W       = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// Register map: index is paddr[4:3]
	localparam int ADDR_W = 5;
	typedef enum logic [1:0] {
		REG_DTC_COUNT = 2'd0,
		REG_PRESCALE  = 2'd1,
		REG_CONFIRM   = 2'd2
	} reg_idx_t;

	// Status byte bit positions
	localparam int STS_TEST_FAILED = 0;
	localparam int STS_CONFIRMED   = 3;

	// Reset value of both byte tables
	localparam logic [63:0] TABLE_RESET = 64'h0101_0101_0101_0101;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [IDX_W-1:0]       idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} seq_state_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [3:0]  dtc_count;
		logic [63:0] prescale_table;
		logic [63:0] confirm_table;
	} cfg_t;

	// Per-code state entering the shared update unit
	typedef struct packed {
		logic fail;
		cnt_t run;
		cnt_t occ;
		cnt_t thr;
		logic conf;
		logic gtaken;
	} step_in_t;

	// Updated per-code state and result flags
	typedef struct packed {
		logic tf;
		cnt_t run;
		cnt_t occ;
		logic conf;
		logic gtaken;
		logic local_cap;
		logic global_cap;
	} step_out_t;

	// Pick the byte of a table for one code; a zero byte counts as one
	function automatic cnt_t tbl_thr(input logic [63:0] tbl, input idx_t idx);
		logic [63:0] sh;
		cnt_t        v;
		sh = tbl >> {idx, 3'b000};
		v  = sh[COUNT_WIDTH-1:0];
		return (v == '0) ? cnt_t'(1) : v;
	endfunction

endpackage

>>> hdl/dtcm_if.sv
// ----------------------------------------------------------------------------
// dtcm_if
// Valid/ready channels for base ticks in and per-code results out.
// ----------------------------------------------------------------------------
interface dtcm_tick_if;
	logic       valid;
	logic       ready;
	logic [7:0] fault_flags;
	logic       monitoring_off;

	modport source (output valid, output fault_flags, output monitoring_off, input ready);
	modport sink   (input valid, input fault_flags, input monitoring_off, output ready);
endinterface

interface dtcm_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] code_index;
	logic [7:0] status_byte;
	logic [7:0] occurrence_count;
	logic       local_capture;
	logic       global_capture;
	logic       last;

	modport source (
		output valid, output code_index, output status_byte, output occurrence_count,
		output local_capture, output global_capture, output last, input ready
	);
	modport sink (
		input valid, input code_index, input status_byte, input occurrence_count,
		input local_capture, input global_capture, input last, output ready
	);
endinterface

>>> hdl/dtcm_regs.sv
// ----------------------------------------------------------------------------
// dtcm_regs
// APB register file: code count, prescale table and confirm table.
// ----------------------------------------------------------------------------
module dtcm_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dtcm_pkg::ADDR_W-1:0]     paddr,
	input  logic [63:0]                     pwdata,
	output logic [63:0]                     prdata,
	output logic                            pready,
	output dtcm_pkg::cfg_t                  cfg
);
	import dtcm_pkg::*;

	logic [3:0]  dtc_count_q;
	logic [63:0] prescale_q;
	logic [63:0] confirm_q;
	logic        wr_en;
	reg_idx_t    reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[4:3]);

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtc_count_q <= '0;
			prescale_q  <= TABLE_RESET;
			confirm_q   <= TABLE_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_DTC_COUNT: dtc_count_q <= pwdata[3:0];
				REG_PRESCALE:  prescale_q  <= pwdata;
				REG_CONFIRM:   confirm_q   <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_sel)
			REG_DTC_COUNT: prdata = {60'd0, dtc_count_q};
			REG_PRESCALE:  prdata = prescale_q;
			REG_CONFIRM:   prdata = confirm_q;
			default:       prdata = '0;
		endcase
	end

	assign cfg.dtc_count      = dtc_count_q;
	assign cfg.prescale_table = prescale_q;
	assign cfg.confirm_table  = confirm_q;

endmodule

>>> hdl/dtcm_step.sv
// ----------------------------------------------------------------------------
// dtcm_step
// Shared per-code update unit: applies one sampled pass or fail to one code.
// ----------------------------------------------------------------------------
module dtcm_step (
	input  dtcm_pkg::step_in_t  sin,
	output dtcm_pkg::step_out_t sout
);
	import dtcm_pkg::*;

	cnt_t run_inc;

	assign run_inc = sin.run + cnt_t'(1);

	always_comb begin
		sout            = '0;
		sout.conf       = sin.conf;
		sout.gtaken     = sin.gtaken;
		sout.occ        = sin.occ;
		if (sin.fail) begin
			sout.tf        = 1'b1;
			sout.local_cap = 1'b1;
			// Saturate the occurrence count
			if (sin.occ != CNT_MAX)
				sout.occ = sin.occ + cnt_t'(1);
			// Confirm once the run reaches the threshold, then restart the run
			if (run_inc >= sin.thr) begin
				sout.run = '0;
				if (!sin.conf) begin
					sout.conf = 1'b1;
					if (!sin.gtaken) begin
						sout.gtaken     = 1'b1;
						sout.global_cap = 1'b1;
					end
				end
			end else begin
				sout.run = run_inc;
			end
		end else begin
			sout.tf  = 1'b0;
			sout.run = '0;
		end
	end

endmodule

>>> hdl/dtc_fault_confirmation_monitor.sv
// ----------------------------------------------------------------------------
// dtc_fault_confirmation_monitor
// Per-tick DTC status update: prescale, sample, count and confirm each code.
//
//   channel  dir  beat contents
//   tick     in   fault_flags, monitoring_off
//   result   out  code_index, status_byte, occurrence_count,
//                 local_capture, global_capture, last
//   apb      cfg  dtc_count @0x00, prescale_table @0x08, confirm_table @0x10
//
// A tick is taken while idle; the prescalers of enabled codes advance then and
// the set of sampled codes is fixed. The shared update unit then walks the
// codes, one code per cycle, up to the highest sampled one. A tick with
// monitoring off or no sample leaves the monitor idle. A stalled result beat
// holds the walk. Reset clears all per-code state at once; there is no sweep.
// ----------------------------------------------------------------------------
module dtc_fault_confirmation_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dtcm_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	dtcm_tick_if.sink                   tick,
	dtcm_result_if.source               result
);
	import dtcm_pkg::*;

	cfg_t       cfg;
	seq_state_t state_q, state_d;

	cnt_t                 presc_q [NUM_CODES];
	cnt_t                 run_q   [NUM_CODES];
	cnt_t                 occ_q   [NUM_CODES];
	logic [NUM_CODES-1:0] tf_q;
	logic [NUM_CODES-1:0] conf_q;
	logic [NUM_CODES-1:0] gt_q;

	logic [NUM_CODES-1:0] mask_q, mask_d, mask_rest;
	logic [7:0]           flags_q;
	idx_t                 idx_q;

	cnt_t                 presc_next [NUM_CODES];
	cnt_t                 presc_inc  [NUM_CODES];
	logic [NUM_CODES-1:0] sample;

	logic      tick_fire, step_fire, out_valid_q;
	step_in_t  sin;
	step_out_t sout;

	dtcm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Prescalers of all enabled codes advance together on a tick
	always_comb begin
		for (int i = 0; i < NUM_CODES; i++) begin
			presc_inc[i]  = presc_q[i] + cnt_t'(1);
			sample[i]     = 1'b0;
			presc_next[i] = presc_q[i];
			if (cfg.dtc_count > 4'(i)) begin
				sample[i]     = presc_inc[i] >= tbl_thr(cfg.prescale_table, idx_t'(i));
				presc_next[i] = sample[i] ? '0 : presc_inc[i];
			end
		end
	end

	assign tick.ready = (state_q == ST_IDLE);
	assign tick_fire  = tick.valid && tick.ready && !tick.monitoring_off;

	// Feed the shared unit with the code under the walk pointer
	assign sin.fail   = flags_q[idx_q];
	assign sin.run    = run_q[idx_q];
	assign sin.occ    = occ_q[idx_q];
	assign sin.thr    = tbl_thr(cfg.confirm_table, idx_q);
	assign sin.conf   = conf_q[idx_q];
	assign sin.gtaken = gt_q[idx_q];

	dtcm_step u_step (
		.sin  (sin),
		.sout (sout)
	);

	always_comb begin
		mask_rest        = mask_q;
		mask_rest[idx_q] = 1'b0;
	end

	// Sequencer: next state and walk control
	always_comb begin
		state_d   = state_q;
		mask_d    = mask_q;
		step_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (tick_fire) begin
					mask_d = sample;
					if (sample != '0)
						state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (mask_q[idx_q]) begin
					step_fire = !out_valid_q || result.ready;
					if (step_fire) begin
						mask_d = mask_rest;
						if (mask_rest == '0)
							state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q  <= '0;
		end else begin
			state_q <= state_d;
			mask_q  <= mask_d;
		end
	end

	// Walk pointer: held at zero while idle, advance past each handled or skipped code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == ST_IDLE) begin
			idx_q <= '0;
		end else if (!mask_q[idx_q] || step_fire) begin
			idx_q <= idx_q + idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire)
			flags_q <= tick.fault_flags;
	end

	// Per-code state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CODES; i++) begin
				presc_q[i] <= '0;
				run_q[i]   <= '0;
				occ_q[i]   <= '0;
			end
			tf_q   <= '0;
			conf_q <= '0;
			gt_q   <= '0;
		end else begin
			if (tick_fire) begin
				for (int i = 0; i < NUM_CODES; i++)
					presc_q[i] <= presc_next[i];
			end
			if (step_fire) begin
				run_q[idx_q]  <= sout.run;
				occ_q[idx_q]  <= sout.occ;
				tf_q[idx_q]   <= sout.tf;
				conf_q[idx_q] <= sout.conf;
				gt_q[idx_q]   <= sout.gtaken;
			end
		end
	end

	// Output register: load on a step, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step_fire)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			result.code_index       <= 3'(idx_q);
			result.status_byte      <= 8'((sout.tf   ? (1 << STS_TEST_FAILED) : 0) |
			                              (sout.conf ? (1 << STS_CONFIRMED)   : 0));
			result.occurrence_count <= 8'(sout.occ);
			result.local_capture    <= sout.local_cap;
			result.global_capture   <= sout.global_cap;
			result.last             <= (mask_rest == '0);
		end
	end

	assign result.valid = out_valid_q;

	// A walk always has a code left to handle
	a_scan_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> mask_q != '0)
		else $error("walk running with empty sample set");

	// A step always presents a result beat next cycle
	a_step_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |=> result.valid)
		else $error("step did not load the result register");

	// Confirmation is sticky
	a_conf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(conf_q & $past(conf_q)) == $past(conf_q))
		else $error("confirmed bit cleared");

	// The global snapshot is taken exactly when a code first confirms
	a_gt_tracks_conf: assert property (@(posedge clk) disable iff (!arst_n)
		gt_q == conf_q)
		else $error("global snapshot mark out of step with confirmation");

endmodule
